// File: rtl/core/swsa_pkg.sv
// ----------------------------------------------------------------------------
// swsa_pkg: shared types and constants
// Fixed-point widths, mode codes, item structs and the arctangent table for
// the six-wheel steering angle pipeline.
// ----------------------------------------------------------------------------
package swsa_pkg;

   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 16;

   localparam int NUM_W  = 16 + FRAC_BITS;   // dividend and radius width
   localparam int REM_W  = 17;               // partial remainder width
   localparam int CW     = FRAC_BITS + 20;   // CORDIC x/y width (signed)
   localparam int ZW     = 34;               // CORDIC angle width (signed)
   localparam int PROD_W = 45;               // 32-bit angle times 13-bit scale
   localparam int LANES  = 6;

   localparam logic [12:0] CENTER      = 13'd3073;
   localparam logic [12:0] FULL_COUNTS = 13'd6146;

   localparam logic [ZW-1:0] QUARTER_TURN = ZW'(34'h0_4000_0000);
   localparam logic [ZW-1:0] HALF_TURN    = ZW'(34'h0_8000_0000);

   localparam int T1 = ((1 << FRAC_BITS) + 50) / 100;
   localparam int T3 = (3 * (1 << FRAC_BITS) + 50) / 100;

   localparam logic [15:0] RST_FRONT  = 16'((54 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [15:0] RST_MIDDLE = 16'((4 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [15:0] RST_REAR   = 16'((29 * (1 << FRAC_BITS) + 50) / 100);
   localparam logic [15:0] RST_AXLE   = 16'((40 * (1 << FRAC_BITS) + 50) / 100);

   localparam logic [1:0] CSR_FRONT  = 2'd0;
   localparam logic [1:0] CSR_MIDDLE = 2'd1;
   localparam logic [1:0] CSR_REAR   = 2'd2;
   localparam logic [1:0] CSR_AXLE   = 2'd3;

   typedef enum logic [1:0] {
      MODE_STRAIGHT = 2'd0,
      MODE_RIGHT    = 2'd1,
      MODE_LEFT     = 2'd2,
      MODE_SPIN     = 2'd3
   } swsa_mode_type;

   typedef struct packed {
      logic signed [15:0] linear_speed;
      logic signed [15:0] yaw_rate;
   } swsa_req_type;

   typedef struct packed {
      logic [12:0] pos_front_a;
      logic [12:0] pos_front_b;
      logic [12:0] pos_middle_a;
      logic [12:0] pos_middle_b;
      logic [12:0] pos_rear_a;
      logic [12:0] pos_rear_b;
      logic [1:0]  steer_mode;
   } swsa_rsp_type;

   typedef struct packed {
      logic              valid;
      logic [15:0]       yaw;
      logic              yzero;
      logic [REM_W-1:0]  rem;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  quo;
      logic [15:0]       den;
   } swsa_div_type;

   typedef struct packed {
      logic                       valid;
      swsa_mode_type              mode;
      logic [LANES-1:0][CW-1:0]   x;
      logic [LANES-1:0][CW-1:0]   y;
      logic [LANES-1:0][ZW-1:0]   z;
   } swsa_cordic_type;

   typedef struct packed {
      logic                         valid;
      swsa_mode_type                mode;
      logic [LANES-1:0][PROD_W-1:0] prod;
   } swsa_post_type;

   // atan(2^-i) as a binary angle, 2^32 = full turn
   function automatic logic [31:0] swsa_atan(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/swsa_div_cell.sv
// ----------------------------------------------------------------------------
// swsa_div_cell: one restoring division step
// Shifts in one dividend bit, subtracts the divisor when it fits and
// registers one quotient bit for the next cell.
// ----------------------------------------------------------------------------
module swsa_div_cell
   import swsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  swsa_div_type din,
   output swsa_div_type dout
);

   swsa_div_type dout_ff, dout_in;
   logic [REM_W-1:0] rem2;
   logic             ge;

   always_comb begin
      rem2    = {din.rem[REM_W-2:0], din.num[NUM_W-1]};
      ge      = rem2 >= REM_W'(din.den);
      dout_in = din;
      dout_in.rem = ge ? rem2 - REM_W'(din.den) : rem2;
      dout_in.num = {din.num[NUM_W-2:0], 1'b0};
      dout_in.quo = {din.quo[NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// File: rtl/core/swsa_cordic_cell.sv
// ----------------------------------------------------------------------------
// swsa_cordic_cell: one vectoring CORDIC iteration over six lanes
// Rotates each lane's vector toward the x axis by atan(2^-step).
// ----------------------------------------------------------------------------
module swsa_cordic_cell
   import swsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic [4:0]      step,
   input  swsa_cordic_type din,
   output swsa_cordic_type dout
);

   swsa_cordic_type dout_ff, dout_in;
   logic signed [CW-1:0] xv [LANES];
   logic signed [CW-1:0] yv [LANES];
   logic signed [CW-1:0] xs [LANES];
   logic signed [CW-1:0] ys [LANES];
   logic [ZW-1:0]        ang;

   always_comb begin
      ang     = ZW'(swsa_atan(step));
      dout_in = din;
      for (int k = 0; k < LANES; k++) begin
         xv[k] = $signed(din.x[k]);
         yv[k] = $signed(din.y[k]);
         xs[k] = xv[k] >>> step;
         ys[k] = yv[k] >>> step;
         // a lane already on the axis holds
         if (yv[k] > 0) begin
            dout_in.x[k] = xv[k] + ys[k];
            dout_in.y[k] = yv[k] - xs[k];
            dout_in.z[k] = din.z[k] + ang;
         end else if (yv[k] < 0) begin
            dout_in.x[k] = xv[k] - ys[k];
            dout_in.y[k] = yv[k] + xs[k];
            dout_in.z[k] = din.z[k] - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dout_ff.valid <= 1'b0;
      end else if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// File: rtl/core/six_wheel_steering_angles_top.sv
// ----------------------------------------------------------------------------
// six_wheel_steering_angles_top: six-wheel steering angle pipeline
// Turns a speed and yaw rate command into six servo positions and a mode.
// ----------------------------------------------------------------------------
// The block takes one command item per clock while the output is not
// stalled and returns one result item per command, in order. A chain of
// NUM_W restoring division cells forms the turn radius, one setup stage
// picks the mode and the wheel vectors, a chain of CORDIC_STEPS cells
// resolves six arctangents side by side, one stage scales the angles to
// counts and the output register presents the item. The whole chain
// advances together and holds while a finished item waits on rsp_ready.
// Offsets and axle width are written through the csr_ port, which is
// always ready; write them only while no item is in flight.
module six_wheel_steering_angles_top
   import swsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  swsa_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output swsa_rsp_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   // configuration registers
   logic [15:0] front_ff, middle_ff, rear_ff, axle_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= RST_FRONT;
         middle_ff <= RST_MIDDLE;
         rear_ff   <= RST_REAR;
         axle_ff   <= RST_AXLE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRONT:  front_ff  <= csr_data;
            CSR_MIDDLE: middle_ff <= csr_data;
            CSR_REAR:   rear_ff   <= csr_data;
            CSR_AXLE:   axle_ff   <= csr_data;
            default:    ;
         endcase
      end
   end

   // one enable for the whole chain: advance whenever the output slot frees
   logic rsp_valid_ff;
   logic advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // --- divider chain: radius = (|lin| << F) / |yaw| ---
   swsa_div_type div_q [NUM_W+1];
   logic [15:0]  alin, ayaw;

   always_comb begin
      alin = req_data.linear_speed[15] ? 16'(-req_data.linear_speed)
                                       : req_data.linear_speed;
      ayaw = req_data.yaw_rate[15] ? 16'(-req_data.yaw_rate) : req_data.yaw_rate;
      div_q[0].valid = req_valid;
      div_q[0].yaw   = req_data.yaw_rate;
      div_q[0].yzero = (ayaw == 16'd0);
      div_q[0].rem   = '0;
      div_q[0].num   = NUM_W'(alin) << FRAC_BITS;
      div_q[0].quo   = '0;
      div_q[0].den   = ayaw;
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_div
      swsa_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .din   (div_q[i]),
         .dout  (div_q[i+1])
      );
   end

   // --- setup stage: mode decision and wheel vectors ---
   swsa_div_type    dv;
   swsa_cordic_type setup_ff, setup_in;
   logic [NUM_W-1:0] radius;
   logic signed [15:0] yaw_s;
   logic turn, spin;
   logic signed [CW-1:0] r2, axle_s, xo, xi;
   logic signed [CW-1:0] lx [LANES];
   logic signed [CW-1:0] ly [LANES];

   always_comb begin
      dv     = div_q[NUM_W];
      // zero yaw rate saturates the radius
      radius = dv.yzero ? (NUM_W'(1) << (NUM_W - 1)) : dv.quo;
      yaw_s  = $signed(dv.yaw);
      turn   = ((yaw_s < -16'(T1)) || (yaw_s > 16'(T1))) && (radius > NUM_W'(T1));
      spin   = !turn && (dv.den > 16'(T3)) && (radius < NUM_W'(T1));

      r2     = CW'({radius, 1'b0});
      axle_s = CW'(axle_ff);
      xo     = r2 + axle_s;
      xi     = r2 - axle_s;

      lx[0] = xo; lx[1] = xi; lx[2] = xo; lx[3] = xi; lx[4] = xo; lx[5] = xi;
      ly[0] = CW'({front_ff, 1'b0});
      ly[1] = CW'({front_ff, 1'b0});
      ly[2] = CW'({middle_ff, 1'b0});
      ly[3] = CW'({middle_ff, 1'b0});
      ly[4] = CW'({rear_ff, 1'b0});
      ly[5] = CW'({rear_ff, 1'b0});
      if (spin) begin
         // spin uses lane zero only
         lx[0] = axle_s;
         ly[0] = CW'(front_ff) + CW'(rear_ff);
      end

      setup_in.valid = dv.valid;
      if (turn) begin
         setup_in.mode = yaw_s[15] ? MODE_RIGHT : MODE_LEFT;
      end else if (spin) begin
         setup_in.mode = MODE_SPIN;
      end else begin
         setup_in.mode = MODE_STRAIGHT;
      end

      for (int k = 0; k < LANES; k++) begin
         // a vector left of the y axis is turned a quarter first
         if (lx[k] < 0) begin
            setup_in.x[k] = ly[k];
            setup_in.y[k] = -lx[k];
            setup_in.z[k] = QUARTER_TURN;
         end else begin
            setup_in.x[k] = lx[k];
            setup_in.y[k] = ly[k];
            setup_in.z[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.valid <= 1'b0;
      end else if (advance) begin
         setup_ff <= setup_in;
      end
   end

   // --- CORDIC chain ---
   swsa_cordic_type cq [CORDIC_STEPS+1];

   assign cq[0] = setup_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      swsa_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .step  (5'(i)),
         .din   (cq[i]),
         .dout  (cq[i+1])
      );
   end

   // --- scale stage: clamp to [0, pi] and multiply by counts per full turn ---
   swsa_cordic_type cv;
   swsa_post_type   post_ff, post_in;
   logic [31:0]     ang [LANES];

   always_comb begin
      cv            = cq[CORDIC_STEPS];
      post_in.valid = cv.valid;
      post_in.mode  = cv.mode;
      for (int k = 0; k < LANES; k++) begin
         if ($signed(cv.z[k]) < 0) begin
            ang[k] = '0;
         end else if ($signed(cv.z[k]) > $signed(HALF_TURN)) begin
            ang[k] = HALF_TURN[31:0];
         end else begin
            ang[k] = cv.z[k][31:0];
         end
         post_in.prod[k] = PROD_W'(ang[k]) * PROD_W'(FULL_COUNTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_ff.valid <= 1'b0;
      end else if (advance) begin
         post_ff <= post_in;
      end
   end

   // --- output stage: map lanes to wheels per mode ---
   logic [12:0] pl [LANES];
   logic [12:0] mi [LANES];
   logic [12:0] fl;
   swsa_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         fl    = post_ff.prod[k][PROD_W-1:32];
         pl[k] = CENTER + fl;
         mi[k] = CENTER - (fl + 13'(|post_ff.prod[k][31:0]));
      end
      rsp_data_in.steer_mode   = post_ff.mode;
      rsp_data_in.pos_front_a  = CENTER;
      rsp_data_in.pos_front_b  = CENTER;
      rsp_data_in.pos_middle_a = CENTER;
      rsp_data_in.pos_middle_b = CENTER;
      rsp_data_in.pos_rear_a   = CENTER;
      rsp_data_in.pos_rear_b   = CENTER;
      case (post_ff.mode)
         MODE_RIGHT: begin
            rsp_data_in.pos_front_a  = pl[0];
            rsp_data_in.pos_front_b  = pl[1];
            rsp_data_in.pos_middle_a = pl[2];
            rsp_data_in.pos_middle_b = pl[3];
            rsp_data_in.pos_rear_a   = mi[4];
            rsp_data_in.pos_rear_b   = mi[5];
         end
         MODE_LEFT: begin
            rsp_data_in.pos_front_a  = mi[1];
            rsp_data_in.pos_front_b  = mi[0];
            rsp_data_in.pos_middle_a = mi[3];
            rsp_data_in.pos_middle_b = mi[2];
            rsp_data_in.pos_rear_a   = pl[5];
            rsp_data_in.pos_rear_b   = pl[4];
         end
         MODE_SPIN: begin
            rsp_data_in.pos_front_a = pl[0];
            rsp_data_in.pos_front_b = mi[0];
            rsp_data_in.pos_rear_a  = mi[0];
            rsp_data_in.pos_rear_b  = pl[0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= post_ff.valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/swsa_checker.sv
// ----------------------------------------------------------------------------
// swsa_port_checks: port-level checks for the steering angle block
// Watches the result channel for handshake and wheel consistency.
// ----------------------------------------------------------------------------
module swsa_port_checks
   import swsa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input swsa_rsp_type rsp_data
);

   // hold a stalled item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.steer_mode == MODE_STRAIGHT |->
         rsp_data.pos_front_a == CENTER && rsp_data.pos_rear_b == CENTER &&
         rsp_data.pos_middle_a == CENTER && rsp_data.pos_middle_b == CENTER)
      else $error("straight item with a wheel off center");

   a_spin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.steer_mode == MODE_SPIN |->
         rsp_data.pos_middle_a == CENTER && rsp_data.pos_middle_b == CENTER &&
         rsp_data.pos_front_a == rsp_data.pos_rear_b &&
         rsp_data.pos_front_b == rsp_data.pos_rear_a)
      else $error("spin item with inconsistent wheels");

   a_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.steer_mode == MODE_RIGHT |->
         rsp_data.pos_front_a >= CENTER && rsp_data.pos_rear_a <= CENTER)
      else $error("right turn with front and rear on the wrong side");

endmodule

bind six_wheel_steering_angles_top swsa_port_checks u_swsa_port_checks (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: dv/swsa_checker.sv
// ----------------------------------------------------------------------------
// swsa_checker: steering result predictor and scoreboard
// Watches the command, result and register channels, works out the six
// servo positions and mode for each accepted command, and compares them in
// order with the results the block returns.
// ----------------------------------------------------------------------------
module swsa_checker
   import swsa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  swsa_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  swsa_rsp_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           errors,
   output int           pending
);

   localparam longint unsigned ANGLE_HALF = 64'h8000_0000;
   localparam longint unsigned ANGLE_QTR  = 64'h4000_0000;
   localparam longint unsigned ARC_STEP [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   logic [15:0]  front_ofs, middle_ofs, rear_ofs, axle_w;
   swsa_rsp_type due_q[$];

   // Vectoring CORDIC: binary angle of (x, y) with y >= 0, clamped to [0, pi].
   function automatic longint unsigned wheel_arc(longint y, longint x);
      longint z, t, nx, ny;
      z = 0;
      if (y == 0 && x == 0) return 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = ANGLE_QTR;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         nx = x;
         ny = y;
         if (y > 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ARC_STEP[i];
         end else if (y < 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= ARC_STEP[i];
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > longint'(ANGLE_HALF)) z = ANGLE_HALF;
      return z;
   endfunction

   function automatic logic [12:0] count_up(longint unsigned a);
      return 13'(64'd3073 + ((a * 64'd6146) >> 32));
   endfunction

   function automatic logic [12:0] count_down(longint unsigned a);
      return 13'(64'd3073 - ((a * 64'd6146 + 64'hFFFF_FFFF) >> 32));
   endfunction

   function automatic swsa_rsp_type steer_positions(swsa_req_type c);
      swsa_rsp_type r;
      longint lin, yaw, alin, ayaw, radius, xo, xi;
      longint unsigned fo, fi, mo, mi, ro, ri, a;
      lin  = longint'(c.linear_speed);
      yaw  = longint'(c.yaw_rate);
      alin = lin < 0 ? -lin : lin;
      ayaw = yaw < 0 ? -yaw : yaw;
      radius = (ayaw == 0) ? (longint'(1) << (15 + FRAC_BITS))
                           : (alin << FRAC_BITS) / ayaw;
      r = '{default: CENTER, steer_mode: MODE_STRAIGHT};
      if ((yaw < -T1 || yaw > T1) && radius > T1) begin
         xo = 2 * radius + longint'(axle_w);
         xi = 2 * radius - longint'(axle_w);
         fo = wheel_arc(2 * longint'(front_ofs), xo);
         fi = wheel_arc(2 * longint'(front_ofs), xi);
         mo = wheel_arc(2 * longint'(middle_ofs), xo);
         mi = wheel_arc(2 * longint'(middle_ofs), xi);
         ro = wheel_arc(2 * longint'(rear_ofs), xo);
         ri = wheel_arc(2 * longint'(rear_ofs), xi);
         if (yaw < 0) begin
            r.steer_mode   = MODE_RIGHT;
            r.pos_front_a  = count_up(fo);
            r.pos_front_b  = count_up(fi);
            r.pos_middle_a = count_up(mo);
            r.pos_middle_b = count_up(mi);
            r.pos_rear_a   = count_down(ro);
            r.pos_rear_b   = count_down(ri);
         end else begin
            r.steer_mode   = MODE_LEFT;
            r.pos_front_a  = count_down(fi);
            r.pos_front_b  = count_down(fo);
            r.pos_middle_a = count_down(mi);
            r.pos_middle_b = count_down(mo);
            r.pos_rear_a   = count_up(ri);
            r.pos_rear_b   = count_up(ro);
         end
      end else if (ayaw > T3 && radius < T1) begin
         a = wheel_arc(longint'(front_ofs) + longint'(rear_ofs), longint'(axle_w));
         r.steer_mode  = MODE_SPIN;
         r.pos_front_a = count_up(a);
         r.pos_front_b = count_down(a);
         r.pos_rear_a  = count_down(a);
         r.pos_rear_b  = count_up(a);
      end
      return r;
   endfunction

   task automatic report(string field, int got, int want);
      $display("MISMATCH t=%0t %s got %0d want %0d", $realtime, field, got, want);
      errors++;
   endtask

   initial errors = 0;
   assign pending = due_q.size();

   always @(posedge clock) begin
      swsa_rsp_type want;
      if (reset) begin
         front_ofs  <= RST_FRONT;
         middle_ofs <= RST_MIDDLE;
         rear_ofs   <= RST_REAR;
         axle_w     <= RST_AXLE;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRONT:  front_ofs  <= csr_data;
               CSR_MIDDLE: middle_ofs <= csr_data;
               CSR_REAR:   rear_ofs   <= csr_data;
               CSR_AXLE:   axle_w     <= csr_data;
            endcase
         end
         if (req_valid && req_ready) due_q.push_back(steer_positions(req_data));
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               want = due_q.pop_front();
               if (rsp_data.pos_front_a != want.pos_front_a)
                  report("pos_front_a", rsp_data.pos_front_a, want.pos_front_a);
               if (rsp_data.pos_front_b != want.pos_front_b)
                  report("pos_front_b", rsp_data.pos_front_b, want.pos_front_b);
               if (rsp_data.pos_middle_a != want.pos_middle_a)
                  report("pos_middle_a", rsp_data.pos_middle_a, want.pos_middle_a);
               if (rsp_data.pos_middle_b != want.pos_middle_b)
                  report("pos_middle_b", rsp_data.pos_middle_b, want.pos_middle_b);
               if (rsp_data.pos_rear_a != want.pos_rear_a)
                  report("pos_rear_a", rsp_data.pos_rear_a, want.pos_rear_a);
               if (rsp_data.pos_rear_b != want.pos_rear_b)
                  report("pos_rear_b", rsp_data.pos_rear_b, want.pos_rear_b);
               if (rsp_data.steer_mode !== want.steer_mode)
                  report("steer_mode", rsp_data.steer_mode, want.steer_mode);
            end
         end
      end
   end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: six-wheel steering angle testbench
// Drives speed and yaw commands through several offset and axle settings,
// stalls both channels at random and lets the checker score every result.
// ----------------------------------------------------------------------------
module tb_top;
   import swsa_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_ITEMS   = 300;

   logic         clock;
   logic         reset;
   logic         req_valid, req_ready;
   swsa_req_type req_data;
   logic         rsp_valid, rsp_ready;
   swsa_rsp_type rsp_data;
   logic         csr_valid, csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;
   int           errors, pending;

   int  idle_cycles;
   bit  quiet;                 // no idling on either side while set
   int  hold_asks, hold_done, hold_left;
   int  sent;

   six_wheel_steering_angles_top dut (.*);

   swsa_checker u_checker (.*);

   // Clock with a 4 unit period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Result side: stall at random, or hold off for a long stretch on request.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_done) begin
         hold_done <= hold_done + 1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 17);
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d items outstanding", pending);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one command and hold it until accepted; optionally idle first.
   task automatic send_cmd(logic signed [15:0] lin, logic signed [15:0] yaw);
      if (!quiet && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{linear_speed: lin, yaw_rate: yaw};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // Drop valid, then wait out every outstanding result and the pipeline.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_geometry(logic [15:0] f, logic [15:0] m, logic [15:0] r,
                                logic [15:0] a);
      write_reg(CSR_FRONT, f);
      write_reg(CSR_MIDDLE, m);
      write_reg(CSR_REAR, r);
      write_reg(CSR_AXLE, a);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Edges of the fields and every mode boundary.
   task automatic directed_cmds;
      send_cmd(16'sd0, 16'sd0);              // both zero
      send_cmd(16'sd32767, 16'sd0);          // zero yaw, radius saturates
      send_cmd(-16'sd32768, 16'sd0);
      send_cmd(16'sd0, 16'sd32767);          // pure spin
      send_cmd(16'sd0, -16'sd32768);
      send_cmd(16'sd32767, 16'sd32767);
      send_cmd(-16'sd32768, -16'sd32768);
      send_cmd(-16'sd32768, 16'sd1);         // small yaw, huge radius
      send_cmd(16'sd4096, -16'sd4096);       // right turn
      send_cmd(16'sd4096, 16'sd4096);        // left turn
      send_cmd(16'sd41, 16'sd4096);          // radius exactly on threshold
      send_cmd(16'sd42, 16'sd4096);
      send_cmd(16'sd4096, 16'sd41);          // yaw exactly on turn threshold
      send_cmd(16'sd4096, 16'sd42);
      send_cmd(16'sd4096, -16'sd42);
      send_cmd(16'sd0, 16'sd123);            // yaw on spin threshold
      send_cmd(16'sd0, 16'sd124);
      send_cmd(16'sd0, -16'sd124);
      send_cmd(16'sd0, 16'sd100);            // small yaw, tiny radius
      send_cmd(16'sd1, -16'sd32768);
      send_cmd(-16'sd1, 16'sd200);
      send_cmd(16'sd10, -16'sd124);
   endtask

   function automatic logic signed [15:0] with_sign(int mag);
      return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
   endfunction

   task automatic random_cmds(int phase);
      int kind, mag;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (phase == 3 && n >= 150 && n < 260);
         if (phase == 1 && n == 100) hold_asks++;      // fill the pipe
         if (phase == 2 && n == 150) drain();          // sender pause
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            send_cmd(16'($urandom), 16'($urandom));
         end else if (kind < 45) begin
            mag = $urandom_range(42, 32767);
            send_cmd(16'($urandom), with_sign(mag));
         end else if (kind < 65) begin
            mag = $urandom_range(124, 32767);
            send_cmd(with_sign($urandom_range(0, mag / 110)), with_sign(mag));
         end else if (kind < 75) begin
            send_cmd(16'($urandom), 16'($signed($urandom_range(0, 82)) - 41));
         end else begin
            send_cmd(with_sign($urandom_range(0, 16000)),
                     with_sign($urandom_range(1, 8000)));
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FRONT;
      csr_data  = '0;
      quiet     = 1'b0;
      hold_asks = 0;
      hold_done = 0;
      hold_left = 0;
      idle_cycles = 0;
      sent      = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Step through geometries: defaults, extremes, a random one, then mixed extremes.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_geometry(RST_FRONT, RST_MIDDLE, RST_REAR, RST_AXLE);
            1: load_geometry(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: load_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: load_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
            default: load_geometry(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF);
         endcase
         directed_cmds();
         random_cmds(phase);
         drain();
      end

      $display("covered %0d commands across 5 geometry settings,", sent);
      $display("with %0d long result stalls and random gaps on both sides", hold_done);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
rtl/core/swsa_pkg.sv
rtl/core/swsa_div_cell.sv
rtl/core/swsa_cordic_cell.sv
rtl/core/six_wheel_steering_angles_top.sv
rtl/core/swsa_checker.sv
dv/swsa_checker.sv
dv/tb_top.sv
